// ===== hdl/macro_sequence_stepper_defines.svh =====
// assertion macros for the macro sequence stepper
`ifndef MACRO_SEQUENCE_STEPPER_DEFINES_SVH
`define MACRO_SEQUENCE_STEPPER_DEFINES_SVH

// property checked on every clock edge outside reset
`define MSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked in the cycle after a trigger
`define MSQ_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);

`endif

// ===== hdl/msq_pkg.sv =====
package msq_pkg;

  localparam int MAX_STEPS = 256;
  localparam int MAX_LOOPS = 16;
  localparam int STEP_AW = $clog2(MAX_STEPS);
  localparam int LOOP_AW = $clog2(MAX_LOOPS);

  localparam logic [2:0] OP_WR_STEP = 3'd0;
  localparam logic [2:0] OP_WR_LOOP = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_ADVANCE = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  localparam logic [1:0] REL_NONE  = 2'd0;
  localparam logic [1:0] REL_FIXED = 2'd1;
  localparam logic [1:0] REL_ABS   = 2'd2;
  localparam logic [1:0] REL_REL   = 2'd3;

  localparam logic [1:0] REG_SEQ_LEN   = 2'd0;
  localparam logic [1:0] REG_LOOP_CNT  = 2'd1;
  localparam logic [1:0] REG_REL_MODE  = 2'd2;
  localparam logic [1:0] REG_REL_START = 2'd3;

  // pass counter code for an endless loop
  localparam logic [8:0] ENDLESS = 9'h1FF;

  // x/15 == (x*RECIP) >> RECIP_SHIFT for every x below 2^16
  localparam logic [15:0] RECIP = 16'd34953;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_REL_RD,
    S_REL_USE,
    S_SCAN,
    S_POP,
    S_PUSH_SCAN,
    S_MEMB,
    S_RS_SCAN,
    S_FINAL,
    S_OUT_RD,
    S_OUT_MUL,
    S_OUT_DIV,
    S_OUT_DONE
  } state_t;

endpackage

// ===== hdl/msq_ram.sv =====
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/msq_scale.sv =====
module msq_scale
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic [7:0]  typ,
  input  logic [7:0]  src,
  output logic [12:0] q
);

  logic [15:0] prod;
  logic [31:0] recip_prod;

  assign recip_prod = prod * RECIP;

  // multiply, then divide by 15 through the reciprocal
  always_ff @(posedge clk) begin
    prod <= typ * src;
    q    <= recip_prod[RECIP_SHIFT +: 13];
  end

endmodule

// ===== hdl/macro_sequence_stepper.sv =====
// channel   direction  handshake           payload
// in        into       in_valid/in_ready   opcode slot step_type step_data loop_*
// out       out of     out_valid/out_ready active position out_type out_data
// cfg       into       apb psel/penable    paddr pwdata prdata
//
// one request at a time; restart pushes the loops that open at step 0, advance pops
// finished loops and then walks the loop records, looking each matching record up in
// the stack, and release does the same walk; absolute and relative release first read
// the reference step, absolute then scans one step a cycle. reset is synchronous and
// the block stays stopped until a restart or a release starts it.
// in_ready is low while a request runs; a request waits for the previous result to be taken.
`include "macro_sequence_stepper_defines.svh"

module macro_sequence_stepper
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  slot,
  input  logic [7:0]  step_type,
  input  logic [15:0] step_data,
  input  logic [7:0]  loop_first,
  input  logic [7:0]  loop_last,
  input  logic [7:0]  loop_repeats,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        active,
  output logic [7:0]  position,
  output logic [12:0] out_type,
  output logic [15:0] out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [8:0]        seq_length;
  logic [4:0]        loop_cnt;
  logic [1:0]        rel_mode;
  logic signed [8:0] rel_start;

  logic [2:0]  op_q;
  logic [7:0]  slot_q;
  logic [7:0]  type_q;
  logic [15:0] data_q;
  logic [7:0]  lf_q;
  logic [7:0]  ll_q;
  logic [7:0]  lr_q;

  logic [7:0] loop_firsts [MAX_LOOPS];
  logic [7:0] loop_lasts  [MAX_LOOPS];
  logic [7:0] loop_passes [MAX_LOOPS];
  logic [7:0] stk_first   [MAX_LOOPS];
  logic [7:0] stk_last    [MAX_LOOPS];
  logic [8:0] stk_left    [MAX_LOOPS];

  logic [LOOP_AW:0]   depth;
  logic [STEP_AW-1:0] cur;
  logic               is_active;
  logic               in_rel;
  logic [7:0]         src;
  logic               unity;

  logic signed [9:0] nxt;
  logic [4:0]        r;
  logic [4:0]        k;
  logic [8:0]        scan_i;
  logic              cmp_vld;
  logic [7:0]        cmp_idx;
  logic [7:0]        crit;

  logic [8:0]         len;
  logic [4:0]         nloops;
  logic signed [9:0]  pos;
  logic signed [9:0]  rs_ext;
  logic signed [9:0]  len_ext;
  logic signed [9:0]  first_ext;
  logic [7:0]         lp_first;
  logic [LOOP_AW-1:0] sidx;
  logic [7:0]         s_first;
  logic [7:0]         s_last;
  logic [8:0]         s_left;
  logic               r_ok;
  logic               k_ok;
  logic               scan_hit;
  logic               scan_end;
  logic               push_do;
  logic               out_load;

  logic               ram_we;
  logic [7:0]         ram_raddr;
  logic [23:0]        ram_rdata;
  logic [7:0]         rd_type;
  logic [12:0]        scaled;
  logic               cfg_wr;

  msq_ram #(.WIDTH(24), .DEPTH(MAX_STEPS)) u_steps (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_q),
    .wdata ({type_q, data_q}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_type = ram_rdata[23:16];

  msq_scale u_scale (
    .clk (clk),
    .typ (rd_type),
    .src (src),
    .q   (scaled)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_length <= 9'd1;
      loop_cnt   <= 5'd0;
      rel_mode   <= REL_NONE;
      rel_start  <= -9'sd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SEQ_LEN:   seq_length <= pwdata[8:0];
        REG_LOOP_CNT:  loop_cnt   <= pwdata[4:0];
        REG_REL_MODE:  rel_mode   <= pwdata[1:0];
        REG_REL_START: rel_start  <= $signed(pwdata[8:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEQ_LEN:   prdata = {23'd0, seq_length};
      REG_LOOP_CNT:  prdata = {27'd0, loop_cnt};
      REG_REL_MODE:  prdata = {30'd0, rel_mode};
      REG_REL_START: prdata = {{23{rel_start[8]}}, rel_start};
      default:       prdata = 32'd0;
    endcase
  end

  // derived values
  assign len       = (seq_length > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : seq_length;
  assign nloops    = (loop_cnt > 5'(MAX_LOOPS)) ? 5'(MAX_LOOPS) : loop_cnt;
  assign pos       = is_active ? $signed({2'b00, cur}) : -10'sd1;
  assign rs_ext    = {rel_start[8], rel_start};
  assign len_ext   = $signed({1'b0, len});
  assign r_ok      = r < nloops;
  assign lp_first  = loop_firsts[r[LOOP_AW-1:0]];
  assign first_ext = $signed({2'b00, lp_first});
  assign k_ok      = k < depth;
  assign sidx      = (state == S_POP) ? LOOP_AW'(depth - 1'b1) : k[LOOP_AW-1:0];
  assign s_first   = stk_first[sidx];
  assign s_last    = stk_last[sidx];
  assign s_left    = stk_left[sidx];
  assign scan_hit  = cmp_vld && (rd_type <= crit);
  assign scan_end  = (scan_i >= len) && !cmp_vld;
  assign push_do   = ((state == S_RS_SCAN) && r_ok && (lp_first == 8'd0)) ||
                     ((state == S_MEMB) && !k_ok);
  assign out_load  = (state == S_OUT_DONE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (op_q)
          OP_RESTART:
            state_next = (rel_start == 9'sd0 || len == 9'd0) ? S_OUT_RD : S_RS_SCAN;
          OP_ADVANCE: state_next = is_active ? S_POP : S_OUT_RD;
          OP_RELEASE: begin
            if (rel_start < 0 || rel_mode == REL_NONE || rel_mode == REL_FIXED ||
                (!is_active && rel_start == 9'sd0)) begin
              state_next = S_PUSH_SCAN;
            end else begin
              state_next = S_REL_RD;
            end
          end
          default: state_next = S_OUT_RD;
        endcase
      end
      S_REL_RD: state_next = S_REL_USE;
      S_REL_USE: state_next = (rel_mode == REL_ABS) ? S_SCAN : S_PUSH_SCAN;
      S_SCAN: if (scan_hit || scan_end) state_next = S_PUSH_SCAN;
      S_POP: begin
        if (depth == '0 || pos != $signed({2'b00, s_last}) || s_left != 9'd0) begin
          state_next = S_PUSH_SCAN;
        end
      end
      S_PUSH_SCAN: begin
        if (!r_ok || nxt < first_ext) begin
          state_next = S_FINAL;
        end else if (nxt == first_ext) begin
          state_next = S_MEMB;
        end
      end
      S_MEMB: begin
        if (!k_ok || (s_first == lp_first && s_last == loop_lasts[r[LOOP_AW-1:0]])) begin
          state_next = S_PUSH_SCAN;
        end
      end
      S_RS_SCAN: if (!(r_ok && lp_first == 8'd0)) state_next = S_OUT_RD;
      S_FINAL:   state_next = S_OUT_RD;
      S_OUT_RD:  state_next = S_OUT_MUL;
      S_OUT_MUL: state_next = S_OUT_DIV;
      S_OUT_DIV: state_next = S_OUT_DONE;
      S_OUT_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = (state == S_IDLE);
    ram_we   = (state == S_EXEC) && (op_q == OP_WR_STEP);
    case (state)
      S_REL_RD: ram_raddr = is_active ? cur : 8'(rel_start - 9'sd1);
      S_SCAN:   ram_raddr = scan_i[7:0];
      default:  ram_raddr = cur;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      cur       <= '0;
      is_active <= 1'b0;
      in_rel    <= 1'b0;
      src       <= 8'd0;
      unity     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_do && depth < 5'(MAX_LOOPS)) begin
        depth <= depth + 1'b1;
      end
      case (state)
        S_EXEC: begin
          if (op_q == OP_RESTART) begin
            depth     <= '0;
            in_rel    <= 1'b0;
            unity     <= 1'b1;
            cur       <= '0;
            is_active <= !(rel_start == 9'sd0 || len == 9'd0);
          end else if (op_q == OP_RELEASE) begin
            depth  <= '0;
            in_rel <= 1'b1;
          end
        end
        S_REL_USE: begin
          if (rel_mode == REL_REL) begin
            src   <= rd_type;
            unity <= 1'b0;
          end
        end
        S_POP: begin
          if (depth != '0 && pos == $signed({2'b00, s_last}) && s_left == 9'd0) begin
            depth <= depth - 1'b1;
          end
        end
        S_FINAL: begin
          if ((!in_rel && nxt == rs_ext) || nxt < 0 || nxt >= len_ext) begin
            is_active <= 1'b0;
            cur       <= '0;
          end else begin
            is_active <= 1'b1;
            cur       <= nxt[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (push_do && depth < 5'(MAX_LOOPS)) begin
      stk_first[depth[LOOP_AW-1:0]] <= lp_first;
      stk_last[depth[LOOP_AW-1:0]]  <= loop_lasts[r[LOOP_AW-1:0]];
      stk_left[depth[LOOP_AW-1:0]]  <= (loop_passes[r[LOOP_AW-1:0]] <= 8'd1) ? ENDLESS :
                                       {1'b0, loop_passes[r[LOOP_AW-1:0]] - 8'd1};
    end
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_q   <= opcode;
          slot_q <= slot;
          type_q <= step_type;
          data_q <= step_data;
          lf_q   <= loop_first;
          ll_q   <= loop_last;
          lr_q   <= loop_repeats;
        end
      end
      S_EXEC: begin
        r <= 5'd0;
        k <= 5'd0;
        if (op_q == OP_WR_LOOP && slot_q < 8'(MAX_LOOPS)) begin
          loop_firsts[slot_q[LOOP_AW-1:0]] <= lf_q;
          loop_lasts[slot_q[LOOP_AW-1:0]]  <= ll_q;
          loop_passes[slot_q[LOOP_AW-1:0]] <= lr_q;
        end
        if (op_q == OP_ADVANCE) begin
          nxt <= pos + 10'sd1;
        end else if (rel_start < 0) begin
          nxt <= -10'sd1;
        end else if (rel_mode == REL_FIXED || rel_mode == REL_REL ||
                     (rel_mode == REL_ABS && !is_active && rel_start == 9'sd0)) begin
          nxt <= rs_ext;
        end else begin
          nxt <= -10'sd1;
        end
      end
      S_REL_USE: begin
        crit    <= rd_type;
        scan_i  <= rel_start;
        cmp_vld <= 1'b0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          nxt <= $signed({2'b00, cmp_idx});
        end else if (!scan_end) begin
          cmp_vld <= scan_i < len;
          cmp_idx <= scan_i[7:0];
          if (scan_i < len) begin
            scan_i <= scan_i + 9'd1;
          end
        end
      end
      S_POP: begin
        if (depth != '0 && pos == $signed({2'b00, s_last}) && s_left != 9'd0) begin
          nxt <= $signed({2'b00, s_first});
          if (s_left != ENDLESS) begin
            stk_left[sidx] <= s_left - 9'd1;
          end
        end
      end
      S_PUSH_SCAN: begin
        if (r_ok && nxt == first_ext) begin
          k <= 5'd0;
        end else if (r_ok && nxt > first_ext) begin
          r <= r + 5'd1;
        end
      end
      S_MEMB: begin
        if (!k_ok || (s_first == lp_first && s_last == loop_lasts[r[LOOP_AW-1:0]])) begin
          r <= r + 5'd1;
        end else begin
          k <= k + 5'd1;
        end
      end
      S_RS_SCAN: if (r_ok && lp_first == 8'd0) r <= r + 5'd1;
      S_OUT_DONE: begin
        if (out_load) begin
          active   <= is_active;
          position <= is_active ? cur : 8'd0;
          out_data <= is_active ? ram_rdata[15:0] : 16'd0;
          if (!is_active) begin
            out_type <= 13'd0;
          end else if (in_rel && !unity) begin
            out_type <= scaled;
          end else begin
            out_type <= {5'd0, rd_type};
          end
        end
      end
      default: ;
    endcase
  end

  `MSQ_ASSERT(a_depth_bound, depth <= 5'(MAX_LOOPS), "loop stack overflow")
  `MSQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
  `MSQ_ASSERT(a_stopped_zero, out_valid && !active |-> position == 8'd0 && out_type == 13'd0,
              "stopped result not cleared")
  `MSQ_ASSERT(a_scan_mode, state == S_SCAN |-> rel_mode == REL_ABS, "scan outside absolute")

endmodule
